[rtl/core/run_length_encoder_escape_core_defines.svh]
// ----------------------------------------------------------------------------
// run length encoder assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_ENCODER_ESCAPE_CORE_DEFINES_SVH
`define RUN_LENGTH_ENCODER_ESCAPE_CORE_DEFINES_SVH

// same-cycle implication
`define RLE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rle check failed");

// next-cycle implication
`define RLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rle check failed");

`endif

[rtl/core/rle_esc_pkg.sv]
// ----------------------------------------------------------------------------
// rle_esc_pkg
// types, constants and the run flush function of the run length encoder
// ----------------------------------------------------------------------------
package rle_esc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ESCAPE_CHAR = 2'd0;
  localparam logic [1:0] CFG_MIN_RUN     = 2'd1;
  localparam logic [1:0] CFG_MAX_RUN     = 2'd2;

  localparam logic [7:0] LETTER_A      = 8'd65;
  localparam logic [4:0] LETTER_SPAN   = 5'd26;
  localparam logic [2:0] LITERAL_CAP   = 3'd4;
  localparam logic [7:0] ESCAPE_RESET  = 8'd126;
  localparam logic [4:0] MIN_RUN_RESET = 5'd4;
  localparam logic [4:0] MAX_RUN_RESET = 5'd26;
  localparam int         BURST_MAX     = 6;

  // bytes of one flushed run, unused slots zero
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } flush_t;

  // result bytes of one input word, byte 0 goes out first
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } burst_t;

  // send a run as an escape triple or as literal bytes
  function automatic flush_t rle_flush(input logic [4:0] cnt, input logic [7:0] rb,
                                       input logic [7:0] esc, input logic [2:0] thr);
    flush_t f;
    f = '0;
    if (cnt != 5'd0) begin
      if (cnt >= {2'b00, thr} || rb == esc) begin
        f.n    = 2'd3;
        f.b[0] = esc;
        f.b[1] = LETTER_A - 8'd1 + {3'b000, cnt};
        f.b[2] = rb;
      end else begin
        // a literal run holds at most three bytes here
        f.n = cnt[1:0];
        for (int i = 0; i < 3; i++) begin
          if (i < int'(cnt)) begin
            f.b[i] = rb;
          end
        end
      end
    end
    return f;
  endfunction

endpackage

[rtl/core/run_length_encoder_escape_core.sv]
// ----------------------------------------------------------------------------
// run_length_encoder_escape_core
// streaming run length encoder with an escape byte
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one uncompressed byte and its final flag a word.
//   out_valid/out_stall carry compressed bytes; out_last marks the last byte
//   caused by one input word. cfg_valid/cfg_ready write escape_char (0),
//   min_run (1) and max_run (2); cfg_ready is always high, write only idle.
// Path: an input word is held in the input register, encoded into a burst
//   of zero to six bytes and loaded into the result register, from which
//   its first byte goes out.
// Throughput: one input word a cycle while each word yields at most one
//   byte and the output does not stall; a word that yields more bytes stalls
//   the next word until its last byte leaves the single result register.
// Reset: clears the pending run, both registers and restores the default
//   configuration (escape 126, min_run 4, max_run 26).
// Stall: a stalled output byte holds; once the burst register is busy the
//   input register fills and in_stall rises until the last byte leaves.
// ----------------------------------------------------------------------------
module run_length_encoder_escape_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rle_esc_pkg::*;

  logic [7:0] escape_char_r;
  logic [4:0] min_run_r;
  logic [4:0] max_run_r;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_final_r;
  logic       ser_ready;
  logic       adv;
  logic       load;
  logic       in_take;
  burst_t     burst;
  logic [4:0] run_count;
  logic [2:0] remain;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_char_r <= ESCAPE_RESET;
      min_run_r     <= MIN_RUN_RESET;
      max_run_r     <= MAX_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ESCAPE_CHAR: escape_char_r <= cfg_data;
        CFG_MIN_RUN:     min_run_r     <= cfg_data[4:0];
        CFG_MAX_RUN:     max_run_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input register handshake
  assign adv      = in_vld_r && ser_ready;
  assign in_stall = in_vld_r && !ser_ready;
  assign in_take  = in_valid && !in_stall;
  assign load     = adv && (burst.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_byte;
      in_final_r <= in_final;
    end
  end

  // encoder and run state
  rle_esc_enc u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_byte     (in_byte_r),
    .in_final    (in_final_r),
    .escape_char (escape_char_r),
    .min_run     (min_run_r),
    .max_run     (max_run_r),
    .burst       (burst),
    .run_count   (run_count)
  );

  // result serializer
  rle_esc_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .remain    (remain)
  );

`include "run_length_encoder_escape_core_defines.svh"

  // a burst never holds more than six bytes
  `RLE_ASSERT_IMPL(a_burst_len, out_valid, remain <= 3'd6)
  // the pending run never passes the last count letter
  `RLE_ASSERT_IMPL(a_run_bound, 1'b1, run_count <= LETTER_SPAN)
  // a loaded burst shows in full on the next cycle
  `RLE_ASSERT_NEXT(a_load_len, load, out_valid && remain == $past(burst.cnt))
  // output drains when the last byte leaves and nothing is loaded
  `RLE_ASSERT_NEXT(a_drain, out_valid && out_last && !out_stall && !load, !out_valid)

endmodule

[rtl/core/rle_esc_enc.sv]
// ----------------------------------------------------------------------------
// rle_esc_enc
// run state and the encoding of one input word into a result burst
// ----------------------------------------------------------------------------
module rle_esc_enc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          in_byte,
  input  logic                in_final,
  input  logic [7:0]          escape_char,
  input  logic [4:0]          min_run,
  input  logic [4:0]          max_run,
  output rle_esc_pkg::burst_t burst,
  output logic [4:0]          run_count
);
  import rle_esc_pkg::*;

  logic [7:0] run_byte_r, run_byte_nxt;
  logic [4:0] run_count_r, run_count_nxt;
  logic [2:0] thr;
  logic [4:0] lim;
  logic       brk;
  logic [4:0] cnt2;
  logic       flush2;
  flush_t     fa, fb;

  // effective thresholds
  always_comb begin
    thr = (min_run > {2'b00, LITERAL_CAP}) ? LITERAL_CAP : min_run[2:0];
    if (max_run == 5'd0) begin
      lim = 5'd1;
    end else if (max_run > LETTER_SPAN) begin
      lim = LETTER_SPAN;
    end else begin
      lim = max_run;
    end
  end

  // old run on a byte change, then the new run when full or final
  always_comb begin
    brk    = (run_count_r != 5'd0) && (in_byte != run_byte_r);
    cnt2   = brk ? 5'd1 : run_count_r + 5'd1;
    flush2 = (cnt2 >= lim) || in_final;
    fa     = rle_flush(brk ? run_count_r : 5'd0, run_byte_r, escape_char, thr);
    fb     = rle_flush(flush2 ? cnt2 : 5'd0, in_byte, escape_char, thr);
    burst.bytes = (48'(fb.b) << {fa.n, 3'b000}) | 48'(fa.b);
    burst.cnt   = {1'b0, fa.n} + {1'b0, fb.n};
    run_byte_nxt  = in_byte;
    run_count_nxt = flush2 ? 5'd0 : cnt2;
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r  <= '0;
      run_count_r <= '0;
    end else if (adv) begin
      run_byte_r  <= run_byte_nxt;
      run_count_r <= run_count_nxt;
    end
  end

  assign run_count = run_count_r;

endmodule

[rtl/core/rle_esc_ser.sv]
// ----------------------------------------------------------------------------
// rle_esc_ser
// result register that sends a burst one byte at a time
// ----------------------------------------------------------------------------
module rle_esc_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rle_esc_pkg::burst_t burst,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [2:0]          remain
);
  import rle_esc_pkg::*;

  logic [BURST_MAX-1:0][7:0] bytes_r;
  logic [2:0]                rem_r;
  logic                      take;

  assign out_valid = (rem_r != 3'd0);
  assign out_byte  = bytes_r[0];
  assign out_last  = (rem_r == 3'd1);
  assign take      = out_valid && !out_stall;
  // free now, or freed by the last byte leaving this cycle
  assign ready     = !out_valid || (out_last && !out_stall);
  assign remain    = rem_r;

  // burst load and shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= burst.cnt;
    end else if (take) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
    end else if (take) begin
      bytes_r <= {8'h00, bytes_r[BURST_MAX-1:1]};
    end
  end

endmodule
